// ===== src/i2c_mbe_pkg.sv =====
// Shared types, constants and helpers for the I2C master bit engine.
// No dependencies; the core, configuration and sequencer files import this package.
package i2c_mbe_pkg;

  localparam int DELAY_COUNTER_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 16;
  localparam logic [7:0] POLL_LIMIT_MAX = 8'd254;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef logic [DELAY_COUNTER_WIDTH-1:0] delay_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_HALF_PERIOD = 2'd0,
    CFG_READ_HIGH   = 2'd1,
    CFG_POLL_LIMIT  = 2'd2
  } cfg_index_t;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_WRITE     = 3'd2,
    OP_WAIT_ACK  = 3'd3,
    OP_READ_ACK  = 3'd4,
    OP_READ_NACK = 3'd5
  } opcode_t;

  typedef enum logic [13:0] {
    PH_IDLE = 14'b00000000000001,
    PH_ST1  = 14'b00000000000010,
    PH_ST2  = 14'b00000000000100,
    PH_SP1  = 14'b00000000001000,
    PH_SP2  = 14'b00000000010000,
    PH_WL   = 14'b00000000100000,
    PH_WH   = 14'b00000001000000,
    PH_A1   = 14'b00000010000000,
    PH_A2   = 14'b00000100000000,
    PH_A3   = 14'b00001000000000,
    PH_RL   = 14'b00010000000000,
    PH_RH   = 14'b00100000000000,
    PH_K1   = 14'b01000000000000,
    PH_K2   = 14'b10000000000000
  } phase_t;

  typedef struct packed {
    logic [15:0] half_period_ticks;
    logic [15:0] read_high_ticks;
    logic [7:0]  ack_poll_limit;
  } cfg_t;

  typedef struct packed {
    logic       command_valid;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       sda_in;
  } cmd_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_error;
  } res_t;

  // Phase length: masked to the counter width, with zero taken as one.
  function automatic delay_t load_len(input logic [15:0] v);
    delay_t x;
    x = delay_t'(v);
    return (x == '0) ? delay_t'(1) : x;
  endfunction

endpackage

// ===== src/i2c_mbe_if.sv =====
// Valid/ready channel interfaces for the command ticks and the pin results.
// Depends on nothing beyond the language.
interface i2c_mbe_in_if;
  logic       valid;
  logic       ready;
  logic       command_valid;
  logic [2:0] opcode;
  logic [7:0] tx_byte;
  logic       sda_in;

  modport source (output valid, command_valid, opcode, tx_byte, sda_in, input ready);
  modport sink (input valid, command_valid, opcode, tx_byte, sda_in, output ready);
endinterface

interface i2c_mbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       sda_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_error;

  modport source (output valid, scl_out, sda_out, sda_enable, busy_res, done_res, rx_byte,
                  ack_error, input ready);
  modport sink (input valid, scl_out, sda_out, sda_enable, busy_res, done_res, rx_byte,
                ack_error, output ready);
endinterface

// ===== src/i2c_master_bit_engine_core.sv =====
// I2C master bit engine, top level: tick input register, sequencer, result register.
// Depends on i2c_mbe_pkg, i2c_mbe_if, i2c_mbe_cfg and i2c_mbe_seq.
//
// Each input beat is one tick of bus time and yields exactly one result beat with the
// SCL/SDA drive levels and status after that tick. The block takes one beat per clock
// while the output is not stalled: a tick is held in the input register and its result
// is then registered into the result register. Phase lengths and the acknowledge poll
// limit are written through the configuration port; the user must write them only while
// no command is running, as the block itself does not enforce this.
module i2c_master_bit_engine_core
  import i2c_mbe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  i2c_mbe_in_if.sink                 in_ch,
  i2c_mbe_out_if.source              out_ch,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  cfg_t cfg;
  cmd_t cmd;
  res_t res_comb, res;
  logic cmd_valid;
  logic out_valid;
  logic advance;

  assign advance     = cmd_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !cmd_valid || advance;

  i2c_mbe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  i2c_mbe_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (cmd),
    .cfg  (cfg),
    .res  (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        cmd_valid <= in_ch.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      cmd.command_valid <= in_ch.command_valid;
      cmd.opcode        <= in_ch.opcode;
      cmd.tx_byte       <= in_ch.tx_byte;
      cmd.sda_in        <= in_ch.sda_in;
    end
    if (advance) begin
      res <= res_comb;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.scl_out    = res.scl_out;
  assign out_ch.sda_out    = res.sda_out;
  assign out_ch.sda_enable = res.sda_enable;
  assign out_ch.busy_res   = res.busy_res;
  assign out_ch.done_res   = res.done_res;
  assign out_ch.rx_byte    = res.rx_byte;
  assign out_ch.ack_error  = res.ack_error;

endmodule

// ===== src/i2c_mbe_cfg.sv =====
// Configuration registers of the I2C master bit engine.
// Depends on i2c_mbe_pkg.
module i2c_mbe_cfg
  import i2c_mbe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= 16'd15;
      cfg.read_high_ticks   <= 16'd1;
      cfg.ack_poll_limit    <= 8'd250;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HALF_PERIOD: cfg.half_period_ticks <= cfg_wdata;
        CFG_READ_HIGH:   cfg.read_high_ticks   <= cfg_wdata;
        CFG_POLL_LIMIT:  cfg.ack_poll_limit    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/i2c_mbe_seq.sv =====
// Phase sequencer: bus state registers and the single-tick update logic.
// Depends on i2c_mbe_pkg.
module i2c_mbe_seq
  import i2c_mbe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  cmd_t cmd,
  input  cfg_t cfg,
  output res_t res
);

  phase_t     phase, phase_next;
  logic [2:0] active_command, active_command_next;
  logic [3:0] bit_counter, bit_counter_next;
  logic [7:0] shift_register, shift_register_next;
  delay_t     delay_counter, delay_counter_next;
  logic [7:0] poll_counter, poll_counter_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       error_flag, error_flag_next;
  logic       sda_drive, sda_drive_next;
  logic [7:0] rx_last, rx_last_next;

  logic       done;
  delay_t     dec;
  logic [7:0] lim;
  logic [7:0] poll_inc;
  logic [3:0] bit_inc;

  always_comb begin
    phase_next          = phase;
    active_command_next = active_command;
    bit_counter_next    = bit_counter;
    shift_register_next = shift_register;
    delay_counter_next  = delay_counter;
    poll_counter_next   = poll_counter;
    scl_level_next      = scl_level;
    sda_level_next      = sda_level;
    error_flag_next     = error_flag;
    sda_drive_next      = sda_drive;
    rx_last_next        = rx_last;
    done                = 1'b0;
    dec      = (delay_counter != '0) ? delay_counter - delay_t'(1) : delay_counter;
    lim      = (cfg.ack_poll_limit > POLL_LIMIT_MAX) ? POLL_LIMIT_MAX : cfg.ack_poll_limit;
    poll_inc = (poll_counter != 8'hFF) ? poll_counter + 8'd1 : poll_counter;
    bit_inc  = bit_counter + 4'd1;

    if (phase == PH_IDLE) begin
      if (cmd.command_valid) begin
        unique case (cmd.opcode)
          OP_START: begin
            active_command_next = cmd.opcode;
            sda_drive_next      = 1'b1;
            sda_level_next      = 1'b1;
            scl_level_next      = 1'b1;
            phase_next          = PH_ST1;
            delay_counter_next  = load_len(cfg.half_period_ticks);
          end
          OP_STOP: begin
            active_command_next = cmd.opcode;
            sda_drive_next      = 1'b1;
            scl_level_next      = 1'b0;
            sda_level_next      = 1'b0;
            phase_next          = PH_SP1;
            delay_counter_next  = load_len(cfg.half_period_ticks);
          end
          OP_WRITE: begin
            active_command_next = cmd.opcode;
            sda_drive_next      = 1'b1;
            scl_level_next      = 1'b0;
            bit_counter_next    = 4'd0;
            sda_level_next      = cmd.tx_byte[7];
            shift_register_next = {cmd.tx_byte[6:0], 1'b0};
            phase_next          = PH_WL;
            delay_counter_next  = load_len(cfg.half_period_ticks);
          end
          OP_WAIT_ACK: begin
            active_command_next = cmd.opcode;
            sda_drive_next      = 1'b0;
            sda_level_next      = 1'b1;
            error_flag_next     = 1'b0;
            poll_counter_next   = 8'd0;
            phase_next          = PH_A1;
            delay_counter_next  = load_len(cfg.half_period_ticks);
          end
          OP_READ_ACK, OP_READ_NACK: begin
            active_command_next = cmd.opcode;
            sda_drive_next      = 1'b0;
            scl_level_next      = 1'b0;
            shift_register_next = 8'd0;
            bit_counter_next    = 4'd0;
            phase_next          = PH_RL;
            delay_counter_next  = load_len(cfg.half_period_ticks);
          end
          default: ;
        endcase
      end
    end else if (phase == PH_A3) begin
      if (!cmd.sda_in) begin
        scl_level_next = 1'b0;
        done           = 1'b1;
      end else begin
        poll_counter_next = poll_inc;
        if (poll_inc > lim) begin
          error_flag_next    = 1'b1;
          sda_drive_next     = 1'b1;
          scl_level_next     = 1'b0;
          sda_level_next     = 1'b0;
          phase_next         = PH_SP1;
          delay_counter_next = load_len(cfg.half_period_ticks);
        end
      end
    end else begin
      delay_counter_next = dec;
      if (dec == '0) begin
        unique case (phase)
          PH_ST1: begin
            sda_level_next     = 1'b0;
            phase_next         = PH_ST2;
            delay_counter_next = load_len(cfg.half_period_ticks);
          end
          PH_ST2: begin
            scl_level_next = 1'b0;
            done           = 1'b1;
          end
          PH_SP1: begin
            scl_level_next     = 1'b1;
            sda_level_next     = 1'b1;
            phase_next         = PH_SP2;
            delay_counter_next = load_len(cfg.half_period_ticks);
          end
          PH_SP2: done = 1'b1;
          PH_WL: begin
            scl_level_next     = 1'b1;
            phase_next         = PH_WH;
            delay_counter_next = load_len(cfg.half_period_ticks);
          end
          PH_WH: begin
            scl_level_next   = 1'b0;
            bit_counter_next = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              done = 1'b1;
            end else begin
              sda_level_next      = shift_register[7];
              shift_register_next = {shift_register[6:0], 1'b0};
              phase_next          = PH_WL;
              delay_counter_next  = load_len(cfg.half_period_ticks);
            end
          end
          PH_A1: begin
            scl_level_next     = 1'b1;
            phase_next         = PH_A2;
            delay_counter_next = load_len(cfg.half_period_ticks);
          end
          PH_A2: begin
            poll_counter_next = 8'd0;
            phase_next        = PH_A3;
          end
          PH_RL: begin
            scl_level_next      = 1'b1;
            shift_register_next = {shift_register[6:0], cmd.sda_in};
            phase_next          = PH_RH;
            delay_counter_next  = load_len(cfg.read_high_ticks);
          end
          PH_RH: begin
            scl_level_next   = 1'b0;
            bit_counter_next = bit_inc;
            if (bit_inc >= BITS_PER_BYTE) begin
              rx_last_next       = shift_register;
              sda_drive_next     = 1'b1;
              sda_level_next     = (active_command == OP_READ_NACK);
              phase_next         = PH_K1;
              delay_counter_next = load_len(cfg.half_period_ticks);
            end else begin
              phase_next         = PH_RL;
              delay_counter_next = load_len(cfg.half_period_ticks);
            end
          end
          PH_K1: begin
            scl_level_next     = 1'b1;
            phase_next         = PH_K2;
            delay_counter_next = load_len(cfg.half_period_ticks);
          end
          PH_K2: begin
            scl_level_next = 1'b0;
            done           = 1'b1;
          end
          default: done = 1'b1;
        endcase
      end
    end

    if (done) begin
      phase_next         = PH_IDLE;
      delay_counter_next = '0;
    end

    res.scl_out    = scl_level_next;
    res.sda_out    = sda_level_next;
    res.sda_enable = sda_drive_next;
    res.busy_res   = (phase_next != PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_last_next;
    res.ack_error  = error_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      active_command <= 3'd0;
      bit_counter    <= 4'd0;
      shift_register <= 8'd0;
      delay_counter  <= '0;
      poll_counter   <= 8'd0;
      scl_level      <= 1'b1;
      sda_level      <= 1'b1;
      error_flag     <= 1'b0;
      sda_drive      <= 1'b1;
      rx_last        <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      active_command <= active_command_next;
      bit_counter    <= bit_counter_next;
      shift_register <= shift_register_next;
      delay_counter  <= delay_counter_next;
      poll_counter   <= poll_counter_next;
      scl_level      <= scl_level_next;
      sda_level      <= sda_level_next;
      error_flag     <= error_flag_next;
      sda_drive      <= sda_drive_next;
      rx_last        <= rx_last_next;
    end
  end

endmodule
